/* rtl/h2r_pkg.sv */
// Shared types and constants for the HSV to RGB converter.
// No dependencies; used by the top level and the testbench.
package h2r_pkg;

    localparam int HUE_BITS = 16;
    localparam int SEC_BITS = 3;

    typedef enum logic [SEC_BITS-1:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

endpackage

/* rtl/hsv_to_rgb_top.sv */
// HSV to RGB pixel converter, four-stage pipeline.
// Depends on h2r_pkg and h2r_scale.
//
// Usage:
//   Input stream s_axis carries one pixel per transaction: hue (fraction of a
//   turn), saturation and brightness (unsigned Q1.FRAC_BITS, values above one
//   saturate to one). Output stream m_axis carries red, green and blue in
//   unsigned Q1.FRAC_BITS.
//   Path: a pixel accepted at one edge is presented on m_axis after passing the
//   four register stages (sector and fraction, first products, second products,
//   channel routing), the first of which loads at the accepting edge.
//   Throughput: one pixel per cycle; each stage advances whenever the stage
//   after it is empty or advancing.
//   Reset: synchronous, active low; clears all stage valid bits, so the
//   pipeline comes up empty and ready.
//   Stall: when m_axis_tready is low, the output holds; earlier stages keep
//   filling bubbles, and s_axis_tready drops only once every stage is full.
module hsv_to_rgb_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // hue[15:0], saturation[FRAC_BITS:0], brightness[FRAC_BITS:0], zero pad
    input  logic [((h2r_pkg::HUE_BITS + 2 * FRAC_BITS + 9) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // red[FRAC_BITS:0], green[FRAC_BITS:0], blue[FRAC_BITS:0], zero pad
    output logic [((3 * FRAC_BITS + 10) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int HB    = h2r_pkg::HUE_BITS;
    localparam int VW    = FRAC_BITS + 1;
    localparam int OUT_W = ((3 * VW + 7) / 8) * 8;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic en1, en2, en3, en4;
    logic r_vld1, r_vld2, r_vld3, r_vld4;

    assign en4 = !r_vld4 || m_axis_tready;
    assign en3 = !r_vld3 || en4;
    assign en2 = !r_vld2 || en3;
    assign en1 = !r_vld1 || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (en1) r_vld1 <= s_axis_tvalid;
            if (en2) r_vld2 <= r_vld1;
            if (en3) r_vld3 <= r_vld2;
            if (en4) r_vld4 <= r_vld3;
        end
    end

    // Stage 1: clamp, hue times six, sector and fraction
    logic [HB-1:0]          in_hue;
    logic [FRAC_BITS:0]     in_sat, in_bri;
    logic [HB+2:0]          h6;
    logic [HB+FRAC_BITS-1:0] frac_ext;
    logic [FRAC_BITS:0]     n_s1, n_v1;
    logic [FRAC_BITS:0]     r_s1, r_v1;
    logic [FRAC_BITS-1:0]   r_f1;
    h2r_pkg::t_sector       r_sec1, r_sec2, r_sec3;
    logic [FRAC_BITS:0]     r_v2, r_v3, r_p3;

    assign in_hue   = s_axis_tdata[HB-1:0];
    assign in_sat   = s_axis_tdata[HB+VW-1:HB];
    assign in_bri   = s_axis_tdata[HB+2*VW-1:HB+VW];
    assign h6       = {3'b000, in_hue} * (HB+3)'(6);
    assign frac_ext = {h6[HB-1:0], {FRAC_BITS{1'b0}}};
    assign n_s1     = (in_sat > ONE) ? ONE : in_sat;
    assign n_v1     = (in_bri > ONE) ? ONE : in_bri;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1   <= n_s1;
            r_v1   <= n_v1;
            r_f1   <= frac_ext[HB+FRAC_BITS-1:HB];
            r_sec1 <= h2r_pkg::t_sector'(h6[HB+2:HB]);
        end
    end

    // Stage 2: s*f, s*(1-f), p = v*(1-s)
    logic [FRAC_BITS:0] sf2, s1f2, p2;
    logic [FRAC_BITS:0] one_m_f, one_m_s;

    assign one_m_f = ONE - {1'b0, r_f1};
    assign one_m_s = ONE - r_s1;

    h2r_scale #(.FRAC_BITS(FRAC_BITS)) u_sf (
        .i_clk(i_clk), .i_en(en2), .i_a(r_s1), .i_b({1'b0, r_f1}), .o_p(sf2)
    );
    h2r_scale #(.FRAC_BITS(FRAC_BITS)) u_s1f (
        .i_clk(i_clk), .i_en(en2), .i_a(r_s1), .i_b(one_m_f), .o_p(s1f2)
    );
    h2r_scale #(.FRAC_BITS(FRAC_BITS)) u_p (
        .i_clk(i_clk), .i_en(en2), .i_a(r_v1), .i_b(one_m_s), .o_p(p2)
    );

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_v2   <= r_v1;
            r_sec2 <= r_sec1;
        end
    end

    // Stage 3: q = v*(1-s*f), t = v*(1-s*(1-f))
    logic [FRAC_BITS:0] q3, t3;

    h2r_scale #(.FRAC_BITS(FRAC_BITS)) u_q (
        .i_clk(i_clk), .i_en(en3), .i_a(r_v2), .i_b(ONE - sf2), .o_p(q3)
    );
    h2r_scale #(.FRAC_BITS(FRAC_BITS)) u_t (
        .i_clk(i_clk), .i_en(en3), .i_a(r_v2), .i_b(ONE - s1f2), .o_p(t3)
    );

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_v3   <= r_v2;
            r_p3   <= p2;
            r_sec3 <= r_sec2;
        end
    end

    // Stage 4: route by sector
    logic [FRAC_BITS:0] n_red, n_grn, n_blu;
    logic [FRAC_BITS:0] r_red, r_grn, r_blu;

    always_comb begin
        case (r_sec3)
            h2r_pkg::SEC_RED_YEL: begin
                n_red = r_v3; n_grn = t3;   n_blu = r_p3;
            end
            h2r_pkg::SEC_YEL_GRN: begin
                n_red = q3;   n_grn = r_v3; n_blu = r_p3;
            end
            h2r_pkg::SEC_GRN_CYN: begin
                n_red = r_p3; n_grn = r_v3; n_blu = t3;
            end
            h2r_pkg::SEC_CYN_BLU: begin
                n_red = r_p3; n_grn = q3;   n_blu = r_v3;
            end
            h2r_pkg::SEC_BLU_MAG: begin
                n_red = t3;   n_grn = r_p3; n_blu = r_v3;
            end
            default: begin
                n_red = r_v3; n_grn = r_p3; n_blu = q3;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_red <= n_red;
            r_grn <= n_grn;
            r_blu <= n_blu;
        end
    end

    assign m_axis_tvalid = r_vld4;
    assign m_axis_tdata  = OUT_W'({r_blu, r_grn, r_red});

`ifndef ASSERT_OFF
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_red <= ONE && r_grn <= ONE && r_blu <= ONE))
        else $error("channel above one");
`endif

endmodule

/* rtl/h2r_scale.sv */
// Registered fixed-point scaling unit: (a * b) >> FRAC_BITS, truncated.
// Depends on nothing; instantiated by hsv_to_rgb_top.
module h2r_scale #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS:0]   i_a,
    input  logic [FRAC_BITS:0]   i_b,
    output logic [FRAC_BITS:0]   o_p
);

    logic [2*FRAC_BITS+1:0] n_prod;
    logic [FRAC_BITS:0]     r_p;

    assign n_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_prod[2*FRAC_BITS:FRAC_BITS];
        end
    end

    assign o_p = r_p;

endmodule

/* tb/hsv_to_rgb_top_test.sv */
// Testbench for hsv_to_rgb_top: corner, random and clamped pixels under random stalls, then
// back-to-back pixels. Each is checked against a bit-exact fixed-point model of the conversion.
// Depends on h2r_pkg and the hsv_to_rgb_top RTL.
module hsv_to_rgb_top_test;

    localparam int FRAC_BITS = 16;
    localparam int IN_W = 56;
    localparam int OUT_W = 56;
    localparam int CH_W = FRAC_BITS + 1;
    localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // hue[15:0], saturation[32:16], brightness[49:33], zero pad
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // red[16:0], green[33:17], blue[50:34], zero pad
    logic [OUT_W-1:0] m_axis_tdata;

    t_rgb expected_rgb[$];
    int in_gap_pct = 0;
    int out_stall_pct = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int mismatches = 0;
    int grey_pixels = 0;
    int clamped_pixels = 0;
    int sector_hits[6];

    hsv_to_rgb_top #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_rgb hsv_pixel_to_rgb(logic [15:0] hue, logic [CH_W-1:0] sat,
                                              logic [CH_W-1:0] val);
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] h6;
        logic [63:0] f;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] t;
        h2r_pkg::t_sector sec;
        t_rgb c;
        s = (64'(sat) > ONE_Q) ? ONE_Q : 64'(sat);
        v = (64'(val) > ONE_Q) ? ONE_Q : 64'(val);
        if (s == 0) begin
            c = '{red: v[CH_W-1:0], green: v[CH_W-1:0], blue: v[CH_W-1:0]};
            return c;
        end
        h6 = 64'(hue) * 64'd6;
        sec = h2r_pkg::t_sector'(h6[h2r_pkg::HUE_BITS +: h2r_pkg::SEC_BITS]);
        f = ((h6 & 64'hFFFF) << FRAC_BITS) >> h2r_pkg::HUE_BITS;
        p = (v * (ONE_Q - s)) >> FRAC_BITS;
        q = (v * (ONE_Q - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
        t = (v * (ONE_Q - ((s * (ONE_Q - f)) >> FRAC_BITS))) >> FRAC_BITS;
        case (sec)
            h2r_pkg::SEC_RED_YEL:
                c = '{red: v[CH_W-1:0], green: t[CH_W-1:0], blue: p[CH_W-1:0]};
            h2r_pkg::SEC_YEL_GRN:
                c = '{red: q[CH_W-1:0], green: v[CH_W-1:0], blue: p[CH_W-1:0]};
            h2r_pkg::SEC_GRN_CYN:
                c = '{red: p[CH_W-1:0], green: v[CH_W-1:0], blue: t[CH_W-1:0]};
            h2r_pkg::SEC_CYN_BLU:
                c = '{red: p[CH_W-1:0], green: q[CH_W-1:0], blue: v[CH_W-1:0]};
            h2r_pkg::SEC_BLU_MAG:
                c = '{red: t[CH_W-1:0], green: p[CH_W-1:0], blue: v[CH_W-1:0]};
            default:
                c = '{red: v[CH_W-1:0], green: p[CH_W-1:0], blue: q[CH_W-1:0]};
        endcase
        return c;
    endfunction

    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(40, 12);
        end
        return $urandom_range(3, 1);
    endfunction

    task automatic send_pixel(logic [15:0] hue, logic [CH_W-1:0] sat, logic [CH_W-1:0] val);
        int gap;
        t_rgb c;
        gap = pick_gap(in_gap_pct);
        c = hsv_pixel_to_rgb(hue, sat, val);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_W - 16 - 2 * CH_W){1'b0}}, val, sat, hue};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_rgb.push_back(c);
        pixels_sent++;
        sector_hits[(32'(hue) * 32'd6) >> h2r_pkg::HUE_BITS]++;
        if (sat == 0) begin
            grey_pixels++;
        end
        if (64'(sat) > ONE_Q || 64'(val) > ONE_Q) begin
            clamped_pixels++;
        end
    endtask

    function automatic logic [CH_W-1:0] pick_level();
        case ($urandom_range(9))
            0: return '0;
            1: return CH_W'(ONE_Q);
            default: return CH_W'($urandom_range(int'(ONE_Q)));
        endcase
    endfunction

    // stall the output side in random bursts
    always @(negedge i_clk) begin
        int g;
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            g = pick_gap(out_stall_pct);
            m_axis_tready <= (g == 0);
            stall_left = (g > 0) ? g - 1 : 0;
        end
    end

    task automatic note_mismatch(string chan, logic [CH_W-1:0] exp_v, logic [CH_W-1:0] act_v);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("pixel %0d %s: expected %0d, got %0d", pixels_checked, chan, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_rgb c;
        t_rgb got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{red: m_axis_tdata[0 +: CH_W], green: m_axis_tdata[CH_W +: CH_W],
                    blue: m_axis_tdata[2 * CH_W +: CH_W]};
            if (expected_rgb.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("unexpected output transaction: %h", m_axis_tdata);
                end
            end else begin
                c = expected_rgb.pop_front();
                if (got.red !== c.red) note_mismatch("red", c.red, got.red);
                if (got.green !== c.green) note_mismatch("green", c.green, got.green);
                if (got.blue !== c.blue) note_mismatch("blue", c.blue, got.blue);
            end
            pixels_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("no transaction for %0d cycles", IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic test_corner_pixels();
        in_gap_pct = 25;
        out_stall_pct = 25;
        send_pixel(16'd0, 17'd0, 17'd0);
        send_pixel(16'd0, 17'd65536, 17'd65536);
        send_pixel(16'd65535, 17'd65536, 17'd65536);
        send_pixel(16'd1, 17'd65536, 17'd65536);
        send_pixel(16'd10922, 17'd65536, 17'd65536);
        send_pixel(16'd10923, 17'd65536, 17'd65536);
        send_pixel(16'd21845, 17'd50000, 17'd60000);
        send_pixel(16'd21846, 17'd50000, 17'd60000);
        send_pixel(16'd32767, 17'd40000, 17'd65536);
        send_pixel(16'd32768, 17'd40000, 17'd65536);
        send_pixel(16'd43690, 17'd30000, 17'd45000);
        send_pixel(16'd43691, 17'd30000, 17'd45000);
        send_pixel(16'd54613, 17'd65535, 17'd65535);
        send_pixel(16'd54614, 17'd65535, 17'd65535);
        send_pixel(16'd20000, 17'd0, 17'd40000);
        send_pixel(16'd50000, 17'd0, 17'd131071);
        send_pixel(16'd30000, 17'd1, 17'd65536);
        send_pixel(16'd12345, 17'd65537, 17'd50000);
        send_pixel(16'd40000, 17'd131071, 17'd50000);
        send_pixel(16'd60000, 17'd50000, 17'd131071);
        send_pixel(16'd5000, 17'd65536, 17'd1);
        send_pixel(16'd65535, 17'd131071, 17'd131071);
        send_pixel(16'd7000, 17'd65536, 17'd0);
        send_pixel(16'd65535, 17'd1, 17'd1);
    endtask

    task automatic test_random_pixels(int count);
        in_gap_pct = 30;
        out_stall_pct = 30;
        repeat (count) send_pixel(16'($urandom_range(65535)), pick_level(), pick_level());
    endtask

    task automatic test_clamped_inputs(int count);
        logic [CH_W-1:0] s;
        logic [CH_W-1:0] v;
        in_gap_pct = 20;
        out_stall_pct = 40;
        repeat (count) begin
            s = ($urandom_range(2) != 0) ? CH_W'($urandom_range(131071, 65537)) : pick_level();
            v = ($urandom_range(2) != 0) ? CH_W'($urandom_range(131071, 65537)) : pick_level();
            send_pixel(16'($urandom_range(65535)), s, v);
        end
    endtask

    task automatic test_back_to_back(int count);
        in_gap_pct = 0;
        out_stall_pct = 0;
        repeat (count) begin
            send_pixel(16'($urandom_range(65535)), CH_W'($urandom_range(131071)),
                       CH_W'($urandom_range(131071)));
        end
    endtask

    task automatic finish_run();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        out_stall_pct = 20;
        while (expected_rgb.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d pixels sent, %0d checked; grey %0d, clamped %0d", pixels_sent,
                 pixels_checked, grey_pixels, clamped_pixels);
        $display("sector hits %0d %0d %0d %0d %0d %0d, %0d mismatches", sector_hits[0],
                 sector_hits[1], sector_hits[2], sector_hits[3], sector_hits[4],
                 sector_hits[5], mismatches);
        if (mismatches == 0 && expected_rgb.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    endtask

    initial begin
        foreach (sector_hits[i]) sector_hits[i] = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_pixels();
        test_random_pixels(700);
        test_clamped_inputs(150);
        test_back_to_back(250);
        finish_run();
    end

endmodule

/* files.f */
rtl/h2r_pkg.sv
rtl/h2r_scale.sv
rtl/hsv_to_rgb_top.sv
tb/hsv_to_rgb_top_test.sv
